FILE: rtl/lag_pkg.sv
package lag_pkg;

    localparam int MAX_QUERY_DEF = 64;
    localparam int MAX_REF_DEF   = 64;

    localparam logic [1:0] MODE_LOAD_Q = 2'd0;
    localparam logic [1:0] MODE_LOAD_R = 2'd1;
    localparam logic [1:0] MODE_RUN    = 2'd2;
    localparam logic [1:0] MODE_READ   = 2'd3;

    localparam logic [1:0] KIND_SUMMARY = 2'd0;
    localparam logic [1:0] KIND_RUN     = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    localparam logic [1:0] OP_M = 2'd0;
    localparam logic [1:0] OP_I = 2'd1;
    localparam logic [1:0] OP_D = 2'd2;

    localparam logic [1:0] CFG_MATCH    = 2'd0;
    localparam logic [1:0] CFG_MISMATCH = 2'd1;
    localparam logic [1:0] CFG_GAP_OPEN = 2'd2;
    localparam logic [1:0] CFG_GAP_EXT  = 2'd3;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD_Q,
        DP_LOAD_R,
        DP_RUN_INIT,
        DP_ROW_PRE,
        DP_CELL,
        DP_TB_INIT,
        DP_TB_RD1,
        DP_TB_RD2,
        DP_TB_DEC,
        DP_SUMMARY,
        DP_OUT_NONE,
        DP_RR_ADDR,
        DP_RR_FIRST,
        DP_RR_CMP,
        DP_RR_OUT
    } t_dp_op;

    typedef struct packed {
        logic empty;
        logic row_end;
        logic last_row;
        logic tb_stop;
        logic h_zero;
        logic no_run;
        logic k_zero;
        logic op_diff;
    } t_dp_status;

endpackage

FILE: rtl/lag_ctrl.sv
module lag_ctrl import lag_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_mode,
    input  t_dp_status i_status,
    output logic       o_busy,
    output t_dp_op     o_op
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ROW_PRE,
        S_CELL,
        S_TB_INIT,
        S_TB_RD1,
        S_TB_RD2,
        S_TB_DEC,
        S_SUMMARY,
        S_RR_FIRST,
        S_RR_CMP,
        S_RR_OUT
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_op    = DP_NOP;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    unique case (i_mode)
                        MODE_LOAD_Q: o_op = DP_LOAD_Q;
                        MODE_LOAD_R: o_op = DP_LOAD_R;
                        MODE_RUN: begin
                            o_op    = DP_RUN_INIT;
                            n_state = S_ROW_PRE;
                        end
                        MODE_READ: begin
                            if (i_status.no_run) begin
                                o_op = DP_OUT_NONE;
                            end else begin
                                o_op    = DP_RR_ADDR;
                                n_state = S_RR_FIRST;
                            end
                        end
                    endcase
                end
            end
            S_ROW_PRE: begin
                if (i_status.empty) begin
                    o_op    = DP_TB_INIT;
                    n_state = S_TB_RD1;
                end else begin
                    o_op    = DP_ROW_PRE;
                    n_state = S_CELL;
                end
            end
            S_CELL: begin
                o_op = DP_CELL;
                if (i_status.row_end) begin
                    n_state = i_status.last_row ? S_TB_INIT : S_ROW_PRE;
                end
            end
            S_TB_INIT: begin
                o_op    = DP_TB_INIT;
                n_state = S_TB_RD1;
            end
            S_TB_RD1: begin
                if (i_status.tb_stop) begin
                    n_state = S_SUMMARY;
                end else begin
                    o_op    = DP_TB_RD1;
                    n_state = S_TB_RD2;
                end
            end
            S_TB_RD2: begin
                if (i_status.h_zero) begin
                    n_state = S_SUMMARY;
                end else begin
                    o_op    = DP_TB_RD2;
                    n_state = S_TB_DEC;
                end
            end
            S_TB_DEC: begin
                o_op    = DP_TB_DEC;
                n_state = S_TB_RD1;
            end
            S_SUMMARY: begin
                o_op    = DP_SUMMARY;
                n_state = S_IDLE;
            end
            S_RR_FIRST: begin
                o_op    = DP_RR_FIRST;
                n_state = i_status.k_zero ? S_RR_OUT : S_RR_CMP;
            end
            S_RR_CMP: begin
                o_op = DP_RR_CMP;
                if (i_status.op_diff || i_status.k_zero) begin
                    n_state = S_RR_OUT;
                end
            end
            S_RR_OUT: begin
                o_op    = DP_RR_OUT;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

FILE: rtl/lag_dp.sv
module lag_dp import lag_pkg::*; #(
    parameter int MAX_QUERY = MAX_QUERY_DEF,
    parameter int MAX_REF   = MAX_REF_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_op            i_op,
    input  logic [5:0]        i_position,
    input  logic [7:0]        i_symbol,
    input  logic [6:0]        i_query_length,
    input  logic [6:0]        i_ref_length,
    input  logic              i_cfg_write,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output t_dp_status        o_status,
    output logic              o_result_valid,
    output logic [1:0]        o_result_kind,
    output logic [15:0]       o_best_score,
    output logic signed [6:0] o_query_end,
    output logic signed [6:0] o_ref_end,
    output logic [1:0]        o_run_op,
    output logic [7:0]        o_run_length,
    output logic              o_last_run
);

    localparam int STRIDE  = MAX_REF + 1;
    localparam int CELLS   = (MAX_QUERY + 1) * STRIDE;
    localparam int MAX_OPS = MAX_QUERY + MAX_REF;
    localparam int QW      = $clog2(MAX_QUERY + 1);
    localparam int RW      = $clog2(MAX_REF + 1);
    localparam int AW      = $clog2(CELLS);
    localparam int QSW     = (MAX_QUERY > 1) ? $clog2(MAX_QUERY) : 1;
    localparam int RSW     = (MAX_REF > 1) ? $clog2(MAX_REF) : 1;
    localparam int OPW     = $clog2(MAX_OPS + 1);
    localparam int OIW     = $clog2(MAX_OPS);
    localparam int MINL    = (MAX_QUERY < MAX_REF) ? MAX_QUERY : MAX_REF;
    localparam int SWC     = $clog2(MINL * 1024) + 2;
    localparam int SW      = (SWC > 18) ? SWC : 18;

    localparam logic [AW-1:0]        STRIDE_A = AW'(STRIDE);
    localparam logic signed [SW-1:0] SAT      = SW'(65535);

    logic signed [10:0] r_match, r_mismatch;
    logic [9:0]         r_go, r_ge;

    logic [7:0]           q_mem  [MAX_QUERY];
    logic [7:0]           r_mem  [MAX_REF];
    logic signed [SW-1:0] h_mem  [CELLS];
    logic signed [SW-1:0] e_mem  [CELLS];
    logic signed [SW-1:0] f_mem  [STRIDE];
    logic [1:0]           op_mem [MAX_OPS];

    logic [7:0]           r_q_rd, r_r_rd;
    logic signed [SW-1:0] r_h_rd, r_e_rd, r_f_rd;
    logic [1:0]           r_op_rd;

    logic [QW-1:0]        r_ql, r_i, r_bi, r_ci;
    logic [RW-1:0]        r_rl, r_j, r_bj, r_cj;
    logic [AW-1:0]        r_base, r_pbase, r_bbase, r_cbase;
    logic signed [SW-1:0] r_hl, r_el, r_diag, r_best, r_hc;
    logic [OPW-1:0]       r_oc, r_rp, r_cnt;
    logic [OIW-1:0]       r_k;
    logic [1:0]           r_rop;

    logic                 r_valid;
    logic [1:0]           r_kind, r_run_op;
    logic [15:0]          r_best_out;
    logic [6:0]           r_qend, r_rend;
    logic [7:0]           r_run_len;
    logic                 r_last;

    logic signed [SW-1:0] go_s, ge_s, sc, hu, fu, e1, e2, f1, f2, e_new, f_new, hd;
    logic signed [SW-1:0] h_new, hdiag;
    logic                 tb_m, tb_d, row_end, op_diff, k_zero;

    always_comb begin
        go_s  = SW'($signed({1'b0, r_go}));
        ge_s  = SW'($signed({1'b0, r_ge}));
        sc    = (r_q_rd == r_r_rd) ? SW'(r_match) : SW'(r_mismatch);
        hu    = (r_i == QW'(1)) ? '0 : r_h_rd;
        fu    = (r_i == QW'(1)) ? '0 : r_f_rd;
        e1    = r_hl - go_s;
        e2    = r_el - ge_s;
        e_new = (e1 > e2) ? e1 : e2;
        f1    = hu - go_s;
        f2    = fu - ge_s;
        f_new = (f1 > f2) ? f1 : f2;
        hd    = r_diag + sc;
        h_new = hd;
        if (e_new > h_new) h_new = e_new;
        if (f_new > h_new) h_new = f_new;
        if (h_new < 0) h_new = '0;
        hdiag = (r_ci == QW'(1) || r_cj == RW'(1)) ? '0 : r_h_rd;
        tb_m  = (r_hc == hdiag + sc);
        tb_d  = (r_hc == r_e_rd);
    end

    assign row_end = (r_j == r_rl);
    assign op_diff = (r_op_rd != r_rop);
    assign k_zero  = (r_k == '0);

    always_comb begin
        o_status.empty    = (r_ql == '0) || (r_rl == '0);
        o_status.row_end  = row_end;
        o_status.last_row = (r_i == r_ql);
        o_status.tb_stop  = (r_ci == '0) || (r_cj == '0) || (r_oc >= OPW'(MAX_OPS));
        o_status.h_zero   = (r_h_rd == '0);
        o_status.no_run   = (r_rp >= r_oc);
        o_status.k_zero   = k_zero;
        o_status.op_diff  = op_diff;
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match    <= 11'sd2;
            r_mismatch <= -11'sd1;
            r_go       <= 10'd3;
            r_ge       <= 10'd1;
        end else if (i_cfg_write) begin
            unique case (i_cfg_index)
                CFG_MATCH:    r_match    <= $signed(i_cfg_data[10:0]);
                CFG_MISMATCH: r_mismatch <= $signed(i_cfg_data[10:0]);
                CFG_GAP_OPEN: r_go       <= i_cfg_data[9:0];
                CFG_GAP_EXT:  r_ge       <= i_cfg_data[9:0];
            endcase
        end
    end

    // symbol stores
    always_ff @(posedge i_clk) begin
        if (i_op == DP_LOAD_Q && int'(i_position) < MAX_QUERY) begin
            q_mem[QSW'(i_position)] <= i_symbol;
        end
        if (i_op == DP_ROW_PRE) begin
            r_q_rd <= q_mem[QSW'(r_i - QW'(1))];
        end else if (i_op == DP_TB_RD1) begin
            r_q_rd <= q_mem[QSW'(r_ci - QW'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == DP_LOAD_R && int'(i_position) < MAX_REF) begin
            r_mem[RSW'(i_position)] <= i_symbol;
        end
        if (i_op == DP_ROW_PRE) begin
            r_r_rd <= r_mem[RSW'(0)];
        end else if (i_op == DP_CELL && !row_end) begin
            r_r_rd <= r_mem[RSW'(r_j)];
        end else if (i_op == DP_TB_RD1) begin
            r_r_rd <= r_mem[RSW'(r_cj - RW'(1))];
        end
    end

    // score matrices
    always_ff @(posedge i_clk) begin
        if (i_op == DP_CELL) begin
            h_mem[r_base + AW'(r_j)] <= h_new;
        end
        if (i_op == DP_ROW_PRE) begin
            r_h_rd <= h_mem[r_pbase + AW'(1)];
        end else if (i_op == DP_CELL) begin
            r_h_rd <= h_mem[r_pbase + AW'(r_j) + AW'(1)];
        end else if (i_op == DP_TB_RD1) begin
            r_h_rd <= h_mem[r_cbase + AW'(r_cj)];
        end else if (i_op == DP_TB_RD2) begin
            r_h_rd <= h_mem[r_cbase + AW'(r_cj) - STRIDE_A - AW'(1)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == DP_CELL) begin
            e_mem[r_base + AW'(r_j)] <= e_new;
        end
        if (i_op == DP_TB_RD1) begin
            r_e_rd <= e_mem[r_cbase + AW'(r_cj)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == DP_CELL) begin
            f_mem[r_j] <= f_new;
        end
        if (i_op == DP_ROW_PRE) begin
            r_f_rd <= f_mem[RW'(1)];
        end else if (i_op == DP_CELL && !row_end) begin
            r_f_rd <= f_mem[r_j + RW'(1)];
        end
    end

    // operation stack
    always_ff @(posedge i_clk) begin
        if (i_op == DP_TB_DEC) begin
            op_mem[OIW'(r_oc)] <= tb_m ? OP_M : (tb_d ? OP_D : OP_I);
        end
        if (i_op == DP_RR_ADDR) begin
            r_op_rd <= op_mem[OIW'(r_oc - r_rp - OPW'(1))];
        end else if ((i_op == DP_RR_FIRST && !k_zero) ||
                     (i_op == DP_RR_CMP && !op_diff && !k_zero)) begin
            r_op_rd <= op_mem[r_k - OIW'(1)];
        end
    end

    // counters and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oc <= '0;
            r_rp <= '0;
        end else begin
            unique case (i_op)
                DP_TB_INIT: begin
                    r_oc <= '0;
                    r_rp <= '0;
                end
                DP_TB_DEC: r_oc <= r_oc + OPW'(1);
                DP_RR_OUT: r_rp <= r_rp + r_cnt;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_op)
            DP_RUN_INIT: begin
                r_ql    <= (int'(i_query_length) > MAX_QUERY) ? QW'(MAX_QUERY)
                                                              : QW'(i_query_length);
                r_rl    <= (int'(i_ref_length) > MAX_REF) ? RW'(MAX_REF)
                                                          : RW'(i_ref_length);
                r_i     <= QW'(1);
                r_base  <= STRIDE_A;
                r_pbase <= '0;
                r_best  <= '0;
                r_bi    <= '0;
                r_bj    <= '0;
                r_bbase <= '0;
            end
            DP_ROW_PRE: begin
                r_j    <= RW'(1);
                r_hl   <= '0;
                r_el   <= '0;
                r_diag <= '0;
            end
            DP_CELL: begin
                r_hl   <= h_new;
                r_el   <= e_new;
                r_diag <= hu;
                if (h_new > r_best) begin
                    r_best  <= h_new;
                    r_bi    <= r_i;
                    r_bj    <= r_j;
                    r_bbase <= r_base;
                end
                if (row_end) begin
                    r_i     <= r_i + QW'(1);
                    r_base  <= r_base + STRIDE_A;
                    r_pbase <= r_pbase + STRIDE_A;
                end else begin
                    r_j <= r_j + RW'(1);
                end
            end
            DP_TB_INIT: begin
                r_ci    <= r_bi;
                r_cj    <= r_bj;
                r_cbase <= r_bbase;
            end
            DP_TB_RD2: r_hc <= r_h_rd;
            DP_TB_DEC: begin
                if (tb_m) begin
                    r_ci    <= r_ci - QW'(1);
                    r_cj    <= r_cj - RW'(1);
                    r_cbase <= r_cbase - STRIDE_A;
                end else if (tb_d) begin
                    r_cj <= r_cj - RW'(1);
                end else begin
                    r_ci    <= r_ci - QW'(1);
                    r_cbase <= r_cbase - STRIDE_A;
                end
            end
            DP_RR_ADDR: r_k <= OIW'(r_oc - r_rp - OPW'(1));
            DP_RR_FIRST: begin
                r_rop <= r_op_rd;
                r_cnt <= OPW'(1);
                if (!k_zero) r_k <= r_k - OIW'(1);
            end
            DP_RR_CMP: begin
                if (!op_diff) begin
                    r_cnt <= r_cnt + OPW'(1);
                    if (!k_zero) r_k <= r_k - OIW'(1);
                end
            end
            default: ;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= (i_op == DP_SUMMARY) || (i_op == DP_OUT_NONE) || (i_op == DP_RR_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op == DP_SUMMARY) begin
            r_kind     <= KIND_SUMMARY;
            r_best_out <= (r_best > SAT) ? 16'hFFFF : 16'(r_best);
            r_qend     <= 7'(r_bi) - 7'd1;
            r_rend     <= 7'(r_bj) - 7'd1;
            r_run_op   <= '0;
            r_run_len  <= '0;
            r_last     <= 1'b0;
        end else if (i_op == DP_RR_OUT) begin
            r_kind     <= KIND_RUN;
            r_best_out <= '0;
            r_qend     <= '0;
            r_rend     <= '0;
            r_run_op   <= r_rop;
            r_run_len  <= 8'(r_cnt);
            r_last     <= ((r_rp + r_cnt) >= r_oc);
        end else if (i_op == DP_OUT_NONE) begin
            r_kind     <= KIND_NONE;
            r_best_out <= '0;
            r_qend     <= '0;
            r_rend     <= '0;
            r_run_op   <= '0;
            r_run_len  <= '0;
            r_last     <= 1'b0;
        end
    end

    assign o_result_valid = r_valid;
    assign o_result_kind  = r_kind;
    assign o_best_score   = r_best_out;
    assign o_query_end    = $signed(r_qend);
    assign o_ref_end      = $signed(r_rend);
    assign o_run_op       = r_run_op;
    assign o_run_length   = r_run_len;
    assign o_last_run     = r_last;

endmodule

FILE: rtl/local_alignment_affine_gap.sv
// Local alignment (affine gaps) of a query against a reference.
// Items enter on start while busy is low; mode selects the item kind:
//   load query / load reference symbol: no result, busy stays low.
//   run: fills the score matrices one cell per cycle within a row, row by row,
//     then traces back from the best cell; each traceback step passes the
//     read, second read and decode states, and the summary item follows.
//   read: returns the next run-length cigar run (or "no run left"); the run is
//     counted by scanning the op stack through its single read port.
// The fill rate is set by the simple dual-port score memories (one cell write
// and one prior-row read per cycle); a row-prime step per row primes the reads.
// Each result is on the result ports for one cycle with o_result_valid high;
// the receiver cannot stall. Config writes use i_cfg_valid/o_cfg_ready
// (always ready) and are legal only while the block is idle.
// Reset restores the default scores, clears the op count and read pointer,
// and leaves the symbol stores undefined until loaded. No clearing pass.
module local_alignment_affine_gap import lag_pkg::*; #(
    parameter int MAX_QUERY = MAX_QUERY_DEF,
    parameter int MAX_REF   = MAX_REF_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_mode,
    input  logic [5:0]        i_position,
    input  logic [7:0]        i_symbol,
    input  logic [6:0]        i_query_length,
    input  logic [6:0]        i_ref_length,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output logic              o_result_valid,
    output logic [1:0]        o_result_kind,
    output logic [15:0]       o_best_score,
    output logic signed [6:0] o_query_end,
    output logic signed [6:0] o_ref_end,
    output logic [1:0]        o_run_op,
    output logic [7:0]        o_run_length,
    output logic              o_last_run
);

    t_dp_op     op;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    lag_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_mode),
        .i_status (status),
        .o_busy   (busy),
        .o_op     (op)
    );

    lag_dp #(
        .MAX_QUERY (MAX_QUERY),
        .MAX_REF   (MAX_REF)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (op),
        .i_position     (i_position),
        .i_symbol       (i_symbol),
        .i_query_length (i_query_length),
        .i_ref_length   (i_ref_length),
        .i_cfg_write    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_status       (status),
        .o_result_valid (o_result_valid),
        .o_result_kind  (o_result_kind),
        .o_best_score   (o_best_score),
        .o_query_end    (o_query_end),
        .o_ref_end      (o_ref_end),
        .o_run_op       (o_run_op),
        .o_run_length   (o_run_length),
        .o_last_run     (o_last_run)
    );

endmodule
